>>> src/word_fifo_sync_framer_top_defines.svh
// Assertion helpers for the framer. Clock and reset names are those of the top level.
`ifndef WORD_FIFO_SYNC_FRAMER_TOP_DEFINES_SVH
`define WORD_FIFO_SYNC_FRAMER_TOP_DEFINES_SVH

`define WFSF_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("framer check failed");

`define WFSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("framer check failed");

`endif

>>> src/wfsf_pkg.sv
`timescale 1ns / 1ps
package wfsf_pkg;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_TXRDY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic {
    BK_RUN  = 1'b0,
    BK_FILL = 1'b1
  } back_state_e;

  localparam logic [31:0] SYNC_WORD   = 32'h89ab_cdef;
  localparam logic [3:0]  FRAME_LEN   = 4'd8;
  localparam logic [7:0]  LIMIT_RESET = 8'd8;

  typedef struct packed {
    func_e       kind;
    logic [31:0] word;
  } cmd_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] tx_byte;
    logic       frame_last;
    logic [5:0] fifo_depth;
    logic       push_dropped;
    logic       tx_error;
    logic [5:0] high_water;
  } result_t;

  typedef struct packed {
    logic filling;
    logic result_push;
  } back_stat_t;

endpackage

>>> src/wfsf_front.sv
`timescale 1ns / 1ps
module wfsf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    func_i,
  input  logic [31:0]   push_word_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output wfsf_pkg::cmd_t cmd_o
);
  import wfsf_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       enq, deq;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.kind = func_e'(func_i);
    // The word only matters for a push; other commands carry zero.
    cmd_in.word = (func_e'(func_i) == FUNC_PUSH) ? push_word_i : 32'd0;
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = entry_q[rd_q];
  assign enq         = push && !full;
  assign deq         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (enq) begin
      entry_q[wr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (enq) begin
        wr_q <= ~wr_q;
      end
      if (deq) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq};
    end
  end

endmodule

>>> src/wfsf_back.sv
`timescale 1ns / 1ps
module wfsf_back #(
  parameter int FIFO_WORDS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          sync_limit_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  wfsf_pkg::cmd_t      cmd_i,
  output logic                empty,
  input  logic                pop,
  output wfsf_pkg::result_t   result_o,
  output wfsf_pkg::back_stat_t stat_o
);
  import wfsf_pkg::*;

  localparam int AW = $clog2(FIFO_WORDS);
  localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_WORDS - 1);

  logic [31:0] mem [FIFO_WORDS];
  logic [31:0] rdata0_q, rdata1_q;

  back_state_e state_q, state_d;
  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d, cnt_q, cnt_d, peak_q, peak_d;
  logic [7:0]    sync_q, sync_d;
  logic [63:0]   frame_q, frame_d;
  logic [3:0]    pos_q, pos_d;
  logic          use0_q, use0_d, use1_q, use1_d;
  logic [AW-1:0] rd_addr0, rd_addr1, rp_next;
  logic          mem_we;
  logic [8:0]    sync_sum;
  logic [2:0]    byte_sel;
  logic [31:0]   w0, w1;

  result_t    res, rq_q [2];
  logic       rq_wr_q, rq_rd_q;
  logic [1:0] rq_cnt_q;
  logic       res_push, res_pop, take;

  function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + AW'(1);
  endfunction

  assign cmd_ready_o = (state_q == BK_RUN) && (rq_cnt_q != 2'd2);
  assign take        = cmd_valid_i && cmd_ready_o;
  assign rp_next     = next_idx(rp_q);
  assign rd_addr0    = rp_q;
  assign rd_addr1    = rp_next;
  assign sync_sum    = {1'b0, sync_q} + 9'd2;
  assign byte_sel    = 3'd7 - pos_q[2:0];
  assign w0          = use0_q ? rdata0_q : SYNC_WORD;
  assign w1          = use1_q ? rdata1_q : SYNC_WORD;

  always_comb begin
    state_d  = state_q;
    wp_d     = wp_q;
    rp_d     = rp_q;
    cnt_d    = cnt_q;
    peak_d   = peak_q;
    sync_d   = sync_q;
    frame_d  = frame_q;
    pos_d    = pos_q;
    use0_d   = use0_q;
    use1_d   = use1_q;
    mem_we   = 1'b0;
    res_push = 1'b0;
    res      = '0;

    case (state_q)
      BK_RUN: begin
        if (take) begin
          res_push = 1'b1;
          case (cmd_i.kind)
            FUNC_PUSH: begin
              if (cnt_q == LAST_IDX) begin
                res.push_dropped = 1'b1;
              end else begin
                mem_we = 1'b1;
                wp_d   = next_idx(wp_q);
                cnt_d  = cnt_q + AW'(1);
              end
            end
            FUNC_TICK: begin
              if (pos_q >= FRAME_LEN) begin
                if (cnt_q > peak_q) begin
                  peak_d = cnt_q;
                end
                use0_d = 1'b0;
                use1_d = 1'b0;
                state_d = BK_FILL;
                if (sync_q < sync_limit_i) begin
                  if (cnt_q == '0) begin
                    // Idle FIFO: count the gap but send nothing.
                    sync_d  = sync_q + 8'd1;
                    state_d = BK_RUN;
                  end else if (cnt_q == AW'(1)) begin
                    use0_d = 1'b1;
                    sync_d = 8'd0;
                  end else begin
                    use0_d = 1'b1;
                    use1_d = 1'b1;
                    sync_d = sync_sum[8] ? 8'hff : sync_sum[7:0];
                  end
                end else begin
                  use0_d = (cnt_q != '0);
                  sync_d = 8'd0;
                end
                if (state_d == BK_FILL) begin
                  // The result is held back until the next cycle, when the word store read is ready.
                  res_push = 1'b0;
                  if (use1_d) begin
                    rp_d  = next_idx(rp_next);
                    cnt_d = cnt_q - AW'(2);
                  end else if (use0_d) begin
                    rp_d  = rp_next;
                    cnt_d = cnt_q - AW'(1);
                  end
                end
              end
            end
            FUNC_TXRDY: begin
              if (pos_q >= FRAME_LEN) begin
                res.tx_error = 1'b1;
              end else begin
                res.byte_valid = 1'b1;
                res.tx_byte    = frame_q[{byte_sel, 3'b000} +: 8];
                res.frame_last = (pos_q == 4'd7);
                pos_d          = pos_q + 4'd1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      BK_FILL: begin
        frame_d        = {w0, w1};
        pos_d          = 4'd1;
        res_push       = 1'b1;
        res.byte_valid = 1'b1;
        res.tx_byte    = w0[31:24];
        state_d        = BK_RUN;
      end
      default: begin
        state_d = BK_RUN;
      end
    endcase

    res.fifo_depth = 6'(cnt_d);
    res.high_water = 6'(peak_d);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wp_q] <= cmd_i.word;
    end
    rdata0_q <= mem[rd_addr0];
    rdata1_q <= mem[rd_addr1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_RUN;
      wp_q    <= '0;
      rp_q    <= '0;
      cnt_q   <= '0;
      peak_q  <= '0;
      sync_q  <= LIMIT_RESET;
      frame_q <= '0;
      pos_q   <= FRAME_LEN;
      use0_q  <= 1'b0;
      use1_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      cnt_q   <= cnt_d;
      peak_q  <= peak_d;
      sync_q  <= sync_d;
      frame_q <= frame_d;
      pos_q   <= pos_d;
      use0_q  <= use0_d;
      use1_q  <= use1_d;
    end
  end

  // Two-entry result queue so new items keep flowing while a result waits.
  assign empty    = (rq_cnt_q == 2'd0);
  assign result_o = rq_q[rq_rd_q];
  assign res_pop  = pop && !empty;

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      rq_q[rq_wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= 1'b0;
      rq_rd_q  <= 1'b0;
      rq_cnt_q <= 2'd0;
    end else begin
      if (res_push) begin
        rq_wr_q <= ~rq_wr_q;
      end
      if (res_pop) begin
        rq_rd_q <= ~rq_rd_q;
      end
      rq_cnt_q <= rq_cnt_q + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

  assign stat_o.filling     = (state_q == BK_FILL);
  assign stat_o.result_push = res_push;

endmodule

>>> src/word_fifo_sync_framer_top.sv
// A result is written to the result queue when its item is accepted; a tick that
// builds a frame pushes its result from the fill state, as it waits for the word store read.
// Throughput: one item per cycle while the result queue has room, except that a
// frame-building tick also holds the executing stage in the fill state. Both ends are decoupled by two-entry queues.
// Reset (rst_ni, asynchronous, active low) empties the queues and the FIFO, sets
// the sync limit and counter to 8 and marks the frame empty; stored words are not cleared.
`timescale 1ns / 1ps
`include "word_fifo_sync_framer_top_defines.svh"
module word_fifo_sync_framer_top #(
  parameter int FIFO_WORDS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  func_i,
  input  logic [31:0] push_word_i,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  output logic        empty,
  input  logic        pop,
  output logic        byte_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        frame_last_o,
  output logic [5:0]  fifo_depth_o,
  output logic        push_dropped_o,
  output logic        tx_error_o,
  output logic [5:0]  high_water_o
);
  import wfsf_pkg::*;

  logic       cmd_valid, cmd_ready;
  cmd_t       cmd;
  result_t    result;
  back_stat_t stat;
  logic [7:0] sync_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      sync_limit_q <= cfg_wdata_i;
    end
  end

  wfsf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .func_i      (func_i),
    .push_word_i (push_word_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  wfsf_back #(
    .FIFO_WORDS (FIFO_WORDS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sync_limit_i (sync_limit_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .empty        (empty),
    .pop          (pop),
    .result_o     (result),
    .stat_o       (stat)
  );

  assign byte_valid_o   = result.byte_valid;
  assign tx_byte_o      = result.tx_byte;
  assign frame_last_o   = result.frame_last;
  assign fifo_depth_o   = result.fifo_depth;
  assign push_dropped_o = result.push_dropped;
  assign tx_error_o     = result.tx_error;
  assign high_water_o   = result.high_water;

  // A frame fill lasts exactly one cycle and always delivers its result.
  `WFSF_ASSERT_NEXT(a_fill_one_cycle, stat.filling, !stat.filling)
  `WFSF_ASSERT_IMPLIES(a_fill_pushes, stat.filling, stat.result_push && !cmd_ready)
  // A result never reports a byte together with an error or a dropped push.
  `WFSF_ASSERT_IMPLIES(a_result_flags, !empty,
                       !(byte_valid_o && (tx_error_o || push_dropped_o)))
  `WFSF_ASSERT_IMPLIES(a_last_has_byte, !empty && frame_last_o, byte_valid_o)

endmodule

>>> verif/word_fifo_sync_framer_top_test.sv
`timescale 1ns / 1ps
module word_fifo_sync_framer_top_test;
  import wfsf_pkg::*;

  localparam int RANDOM_ITEMS  = 1850;
  localparam int PHASES        = 5;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DIR_COUNT     = 25;

  typedef struct packed {
    func_e       f;
    logic [31:0] w;
    logic        typed;
    result_t     exp;
  } dir_row_t;

  // Fields of exp: valid, byte, last, depth, dropped, tx error, high water.
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{FUNC_TXRDY, 32'h0,         1'b1, '{1'b0, 8'h00, 1'b0, 6'd0, 1'b0, 1'b1, 6'd0}},
    '{FUNC_NONE,  32'h0,         1'b1, '{1'b0, 8'h00, 1'b0, 6'd0, 1'b0, 1'b0, 6'd0}},
    '{FUNC_TICK,  32'h0,         1'b1, '{1'b1, 8'h89, 1'b0, 6'd0, 1'b0, 1'b0, 6'd0}},
    '{FUNC_TXRDY, 32'h0,         1'b1, '{1'b1, 8'hab, 1'b0, 6'd0, 1'b0, 1'b0, 6'd0}},
    '{FUNC_TXRDY, 32'h0,         1'b1, '{1'b1, 8'hcd, 1'b0, 6'd0, 1'b0, 1'b0, 6'd0}},
    '{FUNC_TXRDY, 32'h0,         1'b1, '{1'b1, 8'hef, 1'b0, 6'd0, 1'b0, 1'b0, 6'd0}},
    '{FUNC_TXRDY, 32'h0,         1'b1, '{1'b1, 8'h89, 1'b0, 6'd0, 1'b0, 1'b0, 6'd0}},
    '{FUNC_TXRDY, 32'h0,         1'b1, '{1'b1, 8'hab, 1'b0, 6'd0, 1'b0, 1'b0, 6'd0}},
    '{FUNC_TXRDY, 32'h0,         1'b1, '{1'b1, 8'hcd, 1'b0, 6'd0, 1'b0, 1'b0, 6'd0}},
    '{FUNC_TXRDY, 32'h0,         1'b1, '{1'b1, 8'hef, 1'b1, 6'd0, 1'b0, 1'b0, 6'd0}},
    '{FUNC_TXRDY, 32'h0,         1'b1, '{1'b0, 8'h00, 1'b0, 6'd0, 1'b0, 1'b1, 6'd0}},
    '{FUNC_PUSH,  32'hffff_ffff, 1'b1, '{1'b0, 8'h00, 1'b0, 6'd1, 1'b0, 1'b0, 6'd0}},
    '{FUNC_PUSH,  32'h0000_0000, 1'b1, '{1'b0, 8'h00, 1'b0, 6'd2, 1'b0, 1'b0, 6'd0}},
    '{FUNC_PUSH,  32'h1234_5678, 1'b1, '{1'b0, 8'h00, 1'b0, 6'd3, 1'b0, 1'b0, 6'd0}},
    '{FUNC_TICK,  32'h0,         1'b1, '{1'b1, 8'hff, 1'b0, 6'd1, 1'b0, 1'b0, 6'd3}},
    '{FUNC_TICK,  32'h0,         1'b1, '{1'b0, 8'h00, 1'b0, 6'd1, 1'b0, 1'b0, 6'd3}},
    '{FUNC_TXRDY, 32'h0,         1'b1, '{1'b1, 8'hff, 1'b0, 6'd1, 1'b0, 1'b0, 6'd3}},
    '{FUNC_TXRDY, 32'h0,         1'b1, '{1'b1, 8'hff, 1'b0, 6'd1, 1'b0, 1'b0, 6'd3}},
    '{FUNC_TXRDY, 32'h0,         1'b1, '{1'b1, 8'hff, 1'b0, 6'd1, 1'b0, 1'b0, 6'd3}},
    '{FUNC_TXRDY, 32'h0,         1'b1, '{1'b1, 8'h00, 1'b0, 6'd1, 1'b0, 1'b0, 6'd3}},
    '{FUNC_TXRDY, 32'h0,         1'b1, '{1'b1, 8'h00, 1'b0, 6'd1, 1'b0, 1'b0, 6'd3}},
    '{FUNC_TXRDY, 32'h0,         1'b1, '{1'b1, 8'h00, 1'b0, 6'd1, 1'b0, 1'b0, 6'd3}},
    '{FUNC_TXRDY, 32'h0,         1'b1, '{1'b1, 8'h00, 1'b1, 6'd1, 1'b0, 1'b0, 6'd3}},
    '{FUNC_TICK,  32'h0,         1'b0, '0},
    '{FUNC_TXRDY, 32'h0,         1'b0, '0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  func_i = FUNC_NONE;
  logic [31:0] push_word_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        byte_valid_o;
  logic [7:0]  tx_byte_o;
  logic        frame_last_o;
  logic [5:0]  fifo_depth_o;
  logic        push_dropped_o;
  logic        tx_error_o;
  logic [5:0]  high_water_o;

  word_fifo_sync_framer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .func_i        (func_i),
    .push_word_i   (push_word_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .empty         (empty),
    .pop           (pop),
    .byte_valid_o  (byte_valid_o),
    .tx_byte_o     (tx_byte_o),
    .frame_last_o  (frame_last_o),
    .fifo_depth_o  (fifo_depth_o),
    .push_dropped_o(push_dropped_o),
    .tx_error_o    (tx_error_o),
    .high_water_o  (high_water_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Shadow copy of the framer state.
  logic [31:0] word_ring [64];
  logic [5:0]  ring_wr = '0;
  logic [5:0]  ring_rd = '0;
  logic [7:0]  sync_count = LIMIT_RESET;
  logic [7:0]  sync_limit = LIMIT_RESET;
  logic [63:0] frame_word = '0;
  logic [3:0]  frame_pos = FRAME_LEN;
  logic [5:0]  depth_peak = '0;

  result_t queued_results[$];
  int      failures = 0;
  int      items_sent = 0;
  int      cycle_count = 0;
  int      hold_requests = 0;
  int      holds_done = 0;
  int      rx_wait = 0;
  bit      calm = 1'b0;

  function automatic logic [31:0] ring_pop();
    logic [31:0] w;
    w = word_ring[ring_rd];
    ring_rd = ring_rd + 6'd1;
    return w;
  endfunction

  function automatic result_t framer_step(func_e f, logic [31:0] w);
    result_t     r;
    logic [5:0]  n;
    logic [31:0] w0;
    logic [31:0] w1;
    bit          build;
    int          shift;
    r = '0;
    w0 = SYNC_WORD;
    w1 = SYNC_WORD;
    build = 1'b1;
    case (f)
      FUNC_PUSH: begin
        if (6'(ring_wr - ring_rd) == 6'd63) begin
          r.push_dropped = 1'b1;
        end else begin
          word_ring[ring_wr] = w;
          ring_wr = ring_wr + 6'd1;
        end
      end
      FUNC_TICK: begin
        if (frame_pos >= FRAME_LEN) begin
          n = ring_wr - ring_rd;
          if (n > depth_peak) depth_peak = n;
          if (sync_count < sync_limit) begin
            if (n == 6'd0) begin
              sync_count = sync_count + 8'd1;
              build = 1'b0;
            end else if (n == 6'd1) begin
              w0 = ring_pop();
              sync_count = '0;
            end else begin
              w0 = ring_pop();
              w1 = ring_pop();
              sync_count = (sync_count >= 8'd253) ? 8'd255 : sync_count + 8'd2;
            end
          end else begin
            if (n != 6'd0) w0 = ring_pop();
            sync_count = '0;
          end
          if (build) begin
            frame_word = {w0, w1};
            r.byte_valid = 1'b1;
            r.tx_byte = frame_word[63:56];
            frame_pos = 4'd1;
          end
        end
      end
      FUNC_TXRDY: begin
        if (frame_pos >= FRAME_LEN) begin
          r.tx_error = 1'b1;
        end else begin
          shift = 56 - 8 * int'(frame_pos);
          r.byte_valid = 1'b1;
          r.tx_byte = frame_word[shift +: 8];
          frame_pos = frame_pos + 4'd1;
          r.frame_last = (frame_pos == FRAME_LEN);
        end
      end
      default: begin
      end
    endcase
    r.fifo_depth = ring_wr - ring_rd;
    r.high_water = depth_peak;
    return r;
  endfunction

  // Mostly no gap, some short ones, a few long ones, none at all in a calm stretch.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(func_e f, logic [31:0] w, logic typed, result_t exp);
    int      gap;
    result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    func_i <= f;
    push_word_i <= w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predicted = framer_step(f, w);
    queued_results.push_back(typed ? exp : predicted);
    items_sent++;
    if (items_sent % 150 == 0) calm = ($urandom_range(0, 2) == 0);
  endtask

  task automatic write_limit(logic [7:0] value);
    while (queued_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sync_limit = value;
  endtask

  task automatic check_result();
    result_t exp;
    if (queued_results.size() == 0) begin
      $error("result with no expectation waiting");
      failures++;
    end else begin
      exp = queued_results.pop_front();
      if (byte_valid_o !== exp.byte_valid) begin
        $error("byte_valid: expected %0d, got %0d", exp.byte_valid, byte_valid_o);
        failures++;
      end
      if (tx_byte_o !== exp.tx_byte) begin
        $error("tx_byte: expected %0h, got %0h", exp.tx_byte, tx_byte_o);
        failures++;
      end
      if (frame_last_o !== exp.frame_last) begin
        $error("frame_last: expected %0d, got %0d", exp.frame_last, frame_last_o);
        failures++;
      end
      if (fifo_depth_o !== exp.fifo_depth) begin
        $error("fifo_depth: expected %0d, got %0d", exp.fifo_depth, fifo_depth_o);
        failures++;
      end
      if (push_dropped_o !== exp.push_dropped) begin
        $error("push_dropped: expected %0d, got %0d", exp.push_dropped, push_dropped_o);
        failures++;
      end
      if (tx_error_o !== exp.tx_error) begin
        $error("tx_error: expected %0d, got %0d", exp.tx_error, tx_error_o);
        failures++;
      end
      if (high_water_o !== exp.high_water) begin
        $error("high_water: expected %0d, got %0d", exp.high_water, high_water_o);
        failures++;
      end
    end
  endtask

  // Result side: checks each popped item and stalls at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) check_result();
      if (holds_done != hold_requests) begin
        holds_done++;
        rx_wait = LONG_HOLD;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        rx_wait = pick_gap();
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [7:0] limits [PHASES];
    int         phase_end;
    int         bursts;
    int         rdys;
    limits[0] = 8'd1;
    limits[1] = 8'd250;
    limits[2] = 8'($urandom_range(2, 249));
    limits[3] = LIMIT_RESET;
    limits[4] = 8'($urandom_range(2, 20));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_COUNT; i++) begin
      send_item(DIR_ROWS[i].f, DIR_ROWS[i].w, DIR_ROWS[i].typed, DIR_ROWS[i].exp);
    end
    push <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      write_limit(limits[ph]);
      // Two phases start with the result side held off, so the block backs up.
      if (ph == 1 || ph == 3) hold_requests++;
      phase_end = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 99) < 85) begin
          // A frame: a few pushes (now and then enough to overflow), a tick, the bytes.
          bursts = ($urandom_range(0, 19) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 5);
          repeat (bursts) send_item(FUNC_PUSH, $urandom, 1'b0, '0);
          send_item(FUNC_TICK, $urandom, 1'b0, '0);
          rdys = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 10) : 7;
          repeat (rdys) send_item(FUNC_TXRDY, $urandom, 1'b0, '0);
        end else begin
          send_item(func_e'(2'($urandom_range(0, 3))), $urandom, 1'b0, '0);
        end
      end
      push <= 1'b0;
    end

    while (queued_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
